// ===== sv/ttps_pkg.sv =====
// ----------------------------------------------------------------------------
// ttps_pkg: shared types and constants of the transposition table probe store
// Holds the table geometry, the function and bound kind codes, the entry and
// row layout, the request payload and the controller state type.
// ----------------------------------------------------------------------------
package ttps_pkg;

   // Table geometry.
   localparam int MAX_INDEX_BITS = 16;
   localparam int MIN_INDEX_BITS = 4;
   localparam int TBL_DEPTH      = 1 << MAX_INDEX_BITS;

   // Field widths.
   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 64;
   localparam int DEPTH_W = 6;
   localparam int SCORE_W = 16;
   localparam int MOVE_W  = 16;
   localparam int EPOCH_W = 8;
   localparam int IDXB_W  = 5;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_ENABLE  = 2'd0,
      CSR_INDEX_BITS    = 2'd1,
      CSR_CURRENT_EPOCH = 2'd2
   } csr_index_type;

   // Request functions.
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PROBE = 2'd0,
      FUNC_STORE = 2'd1,
      FUNC_ROOT  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // Bound kind of a stored entry; empty never matches a key.
   typedef enum logic [1:0] {
      KIND_EMPTY = 2'd0,
      KIND_EXACT = 2'd1,
      KIND_UPPER = 2'd2,
      KIND_LOWER = 2'd3
   } kind_type;

   // Entry layout, most significant field first.
   typedef struct packed {
      kind_type                   kind;
      logic [EPOCH_W-1:0]         epoch;
      logic [DEPTH_W-1:0]         depth;
      logic signed [SCORE_W-1:0]  score;
      logic [MOVE_W-1:0]          move;
   } entry_type;

   // One memory row: the full key next to its entry.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      entry_type        entry;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // Request payload as held in the lookup stage.
   typedef struct packed {
      func_type                   func;
      logic [KEY_W-1:0]           key;
      logic [DEPTH_W-1:0]         depth;
      logic signed [SCORE_W-1:0]  alpha;
      logic signed [SCORE_W-1:0]  beta;
      logic signed [SCORE_W-1:0]  score;
      logic [MOVE_W-1:0]          move;
   } req_type;

   // Controller states.
   typedef enum logic {
      ST_SWEEP = 1'b0,
      ST_RUN   = 1'b1
   } state_type;

endpackage

// ===== sv/ttps_req_if.sv =====
// ----------------------------------------------------------------------------
// ttps_req_if: request channel of the transposition table probe store
// Valid and ready handshake carrying one probe, store, root or clear transaction.
// ----------------------------------------------------------------------------
interface ttps_req_if;
   import ttps_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [KEY_W-1:0]           key;
   logic [DEPTH_W-1:0]         depth;
   logic signed [SCORE_W-1:0]  alpha;
   logic signed [SCORE_W-1:0]  beta;
   logic signed [SCORE_W-1:0]  score;
   logic [MOVE_W-1:0]          move;

   modport source (output valid, func, key, depth, alpha, beta, score, move,
                   input ready);
   modport sink   (input valid, func, key, depth, alpha, beta, score, move,
                   output ready);
endinterface

// ----------------------------------------------------------------------------
// ttps_rsp_if: response channel of the transposition table probe store
// Valid and ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface ttps_rsp_if;
   import ttps_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic signed [SCORE_W-1:0]  cut_score;
   logic [MOVE_W-1:0]          hint_move;
   logic                       written;

   modport source (output valid, hit, cut_score, hint_move, written,
                   input ready);
   modport sink   (input valid, hit, cut_score, hint_move, written,
                   output ready);
endinterface

// ===== sv/ttps_ram.sv =====
// ----------------------------------------------------------------------------
// ttps_ram: generic single-clock RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module ttps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/transposition_table_probe_store.sv =====
// Pipeline: the memory read and the lookup stage registers load at the accepting
// edge, then lookup and write-back into the result register once it is free.
// Throughput: one transaction per cycle while results are taken; a write
// followed at once by a read of the same entry is served from a forwarding register.
// Clear: sweeps all 65536 rows, one per cycle, then answers; a sweep of the
// same length runs after reset, and no request is accepted during a sweep.
// ----------------------------------------------------------------------------
// transposition_table_probe_store: direct-mapped search transposition table
// Probes return a cutoff score and a move hint; stores apply the depth and
// age replacement rule; clear zeroes the table. Key and entry share one RAM.
// ----------------------------------------------------------------------------
module transposition_table_probe_store (
   input  logic                            clock,
   input  logic                            reset,
   ttps_req_if.sink                        req_ch,
   ttps_rsp_if.source                      rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [ttps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ttps_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import ttps_pkg::*;

   // Configuration registers.
   logic               cfg_enable_ff;
   logic [IDXB_W-1:0]  cfg_index_bits_ff;
   logic [EPOCH_W-1:0] cfg_epoch_ff;

   // Controller state and sweep counter.
   state_type                 state_ff, state_in;
   logic [MAX_INDEX_BITS-1:0] clr_idx_ff, clr_idx_in;

   // Lookup stage.
   logic                      s2_valid_ff;
   req_type                   s2_ff;
   logic [MAX_INDEX_BITS-1:0] s2_slot_ff;
   logic                      s2_fwd_ff;
   row_type                   fwd_row_ff;
   logic                      s2_adv;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic signed [SCORE_W-1:0] rsp_cut_ff;
   logic [MOVE_W-1:0]         rsp_hint_ff;
   logic                      rsp_written_ff;

   // Request side.
   logic                      req_accept;
   logic [IDXB_W-1:0]         idx_clamp;
   logic [MAX_INDEX_BITS-1:0] slot_mask;
   logic [MAX_INDEX_BITS-1:0] req_slot;
   req_type                   req_item;

   // Memory ports.
   logic                      ram_wr_en;
   logic [MAX_INDEX_BITS-1:0] ram_wr_addr;
   row_type                   ram_wr_row;
   logic [ROW_W-1:0]          ram_rd_data;

   // Lookup results.
   row_type                   row;
   logic                      key_match;
   logic                      lk_wr;
   kind_type                  lk_kind;
   logic                      lk_hit;
   logic signed [SCORE_W-1:0] lk_cut;
   logic [MOVE_W-1:0]         lk_hint;
   logic                      lk_written;
   row_type                   lk_row;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_enable_ff     <= 1'b1;
         cfg_index_bits_ff <= IDXB_W'(MAX_INDEX_BITS);
         cfg_epoch_ff      <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TABLE_ENABLE:  cfg_enable_ff     <= csr_wr_data[0];
            CSR_INDEX_BITS:    cfg_index_bits_ff <= csr_wr_data[IDXB_W-1:0];
            CSR_CURRENT_EPOCH: cfg_epoch_ff      <= csr_wr_data[EPOCH_W-1:0];
            default: ;
         endcase
      end
   end

   // Slot selection: low key bits under a mask of the clamped index width.
   always_comb begin
      if (cfg_index_bits_ff < IDXB_W'(MIN_INDEX_BITS)) begin
         idx_clamp = IDXB_W'(MIN_INDEX_BITS);
      end else if (cfg_index_bits_ff > IDXB_W'(MAX_INDEX_BITS)) begin
         idx_clamp = IDXB_W'(MAX_INDEX_BITS);
      end else begin
         idx_clamp = cfg_index_bits_ff;
      end
      for (int i = 0; i < MAX_INDEX_BITS; i++) begin
         slot_mask[i] = (IDXB_W'(i) < idx_clamp);
      end
      req_slot = req_ch.key[MAX_INDEX_BITS-1:0] & slot_mask;
   end

   always_comb begin
      req_item.func  = func_type'(req_ch.func);
      req_item.key   = req_ch.key;
      req_item.depth = req_ch.depth;
      req_item.alpha = req_ch.alpha;
      req_item.beta  = req_ch.beta;
      req_item.score = req_ch.score;
      req_item.move  = req_ch.move;
   end

   // Handshake: the lookup stage moves on when the result register is free.
   assign s2_adv       = s2_valid_ff && (state_ff == ST_RUN) &&
                         (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = (state_ff == ST_RUN) && (!s2_valid_ff || s2_adv);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // Controller: a sweep runs after reset and after a clear is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         clr_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_idx_in = clr_idx_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            clr_idx_in = clr_idx_ff + 1'b1;
            if (&clr_idx_ff) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (req_accept && (req_item.func == FUNC_CLEAR)) begin
               state_in = ST_SWEEP;
            end
         end
         default: state_in = ST_SWEEP;
      endcase
   end

   // Memory: the sweep owns the write port while it runs.
   assign ram_wr_en   = (state_ff == ST_SWEEP) || (s2_adv && lk_wr);
   assign ram_wr_addr = (state_ff == ST_SWEEP) ? clr_idx_ff : s2_slot_ff;
   assign ram_wr_row  = (state_ff == ST_SWEEP) ? row_type'('0) : lk_row;

   ttps_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TBL_DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_row),
      .rd_en      (req_accept),
      .rd_addr    (req_slot),
      .rd_data_ff (ram_rd_data)
   );

   // Lookup stage registers, with a forward of a write to the slot being read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s2_valid_ff <= 1'b1;
      end else if (s2_adv) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s2_ff      <= req_item;
         s2_slot_ff <= req_slot;
         s2_fwd_ff  <= ram_wr_en && (ram_wr_addr == req_slot);
         fwd_row_ff <= ram_wr_row;
      end
   end

   // Lookup: probe decision, replacement rule and the new row.
   always_comb begin
      row        = s2_fwd_ff ? fwd_row_ff : row_type'(ram_rd_data);
      key_match  = (row.entry.kind != KIND_EMPTY) && (row.key == s2_ff.key);
      lk_wr      = 1'b0;
      lk_kind    = KIND_EXACT;
      lk_hit     = 1'b0;
      lk_cut     = '0;
      lk_hint    = '0;
      lk_written = 1'b0;
      unique case (s2_ff.func)
         FUNC_PROBE: begin
            if (cfg_enable_ff && key_match) begin
               lk_hint = row.entry.move;
               if (row.entry.depth >= s2_ff.depth) begin
                  case (row.entry.kind)
                     KIND_EXACT: begin
                        lk_hit = 1'b1;
                        lk_cut = row.entry.score;
                     end
                     KIND_UPPER: begin
                        if (row.entry.score <= s2_ff.alpha) begin
                           lk_hit = 1'b1;
                           lk_cut = s2_ff.alpha;
                        end
                     end
                     KIND_LOWER: begin
                        if (row.entry.score >= s2_ff.beta) begin
                           lk_hit = 1'b1;
                           lk_cut = s2_ff.beta;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         FUNC_STORE: begin
            // A deeper resident of the present epoch is kept.
            if (cfg_enable_ff &&
                (key_match || !((row.entry.depth > s2_ff.depth) &&
                                (row.entry.epoch == cfg_epoch_ff)))) begin
               lk_wr = 1'b1;
               if (s2_ff.score <= s2_ff.alpha) begin
                  lk_kind = KIND_UPPER;
               end else if (s2_ff.score >= s2_ff.beta) begin
                  lk_kind = KIND_LOWER;
               end else begin
                  lk_kind = KIND_EXACT;
               end
            end
         end
         FUNC_ROOT: begin
            lk_wr = cfg_enable_ff;
         end
         FUNC_CLEAR: begin
            lk_written = 1'b1;
         end
         default: ;
      endcase
      if (lk_wr) begin
         lk_written = 1'b1;
      end
      lk_row.key         = s2_ff.key;
      lk_row.entry.kind  = lk_kind;
      lk_row.entry.epoch = cfg_epoch_ff;
      lk_row.entry.depth = s2_ff.depth;
      lk_row.entry.score = s2_ff.score;
      lk_row.entry.move  = s2_ff.move;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_hit_ff     <= lk_hit;
         rsp_cut_ff     <= lk_cut;
         rsp_hint_ff    <= lk_hint;
         rsp_written_ff <= lk_written;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.hit       = rsp_hit_ff;
   assign rsp_ch.cut_score = rsp_cut_ff;
   assign rsp_ch.hint_move = rsp_hint_ff;
   assign rsp_ch.written   = rsp_written_ff;

   // A new result only appears when the lookup stage hands one over.
   a_rsp_from_stage : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_adv))
      else $error("result appeared without a lookup transaction");

   // The sweep counter wraps back to zero when a sweep ends.
   a_sweep_idle_zero : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (clr_idx_ff == '0))
      else $error("sweep counter not at zero outside a sweep");

   // A clear is answered with written set.
   a_clear_written : assert property (@(posedge clock) disable iff (reset)
      (s2_adv && (s2_ff.func == FUNC_CLEAR)) |=> rsp_written_ff)
      else $error("clear answered without written");

   // A probe never writes the memory and never reports written.
   a_probe_no_write : assert property (@(posedge clock) disable iff (reset)
      (s2_adv && (s2_ff.func == FUNC_PROBE)) |-> (!lk_wr && !lk_written))
      else $error("probe caused a write");

   // No stage-two write while a sweep owns the memory.
   a_sweep_excl : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !s2_adv)
      else $error("lookup advanced during a sweep");

endmodule
